### src/fbpa_pkg.sv
// Shared types and constants for the fixed block pool allocator.
package fbpa_pkg;

  localparam int POOL_DEPTH = 1024;
  localparam int QW         = $clog2(POOL_DEPTH);
  localparam int IDX_W      = QW + 1;
  localparam int OFF_W      = 26;
  localparam int USZ_W      = 16;
  localparam int UNITS_W    = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_W      = 16;
  localparam int MIN_UNIT   = 8;
  localparam int PROD_W     = IDX_W + USZ_W;

  localparam int DIV_STEPS  = (QW + 1) / 2;
  localparam int Q2_W       = 2 * DIV_STEPS;
  localparam int DSH_W      = USZ_W + Q2_W - 1;
  localparam int DIV_W      = (OFF_W > DSH_W) ? OFF_W : DSH_W;
  localparam int CNT_W      = $clog2(DIV_STEPS + 1);

  localparam logic [IDX_W-1:0] NULL_IDX = IDX_W'(POOL_DEPTH);

  localparam logic [CFG_IDX_W-1:0] CFG_UNIT_SIZE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_UNITS = CFG_IDX_W'(1);

  typedef enum logic {
    FUNC_ALLOC,
    FUNC_FREE
  } func_t;

  typedef enum logic [1:0] {
    STAT_OK,
    STAT_EXHAUSTED,
    STAT_BAD_OFFSET
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP,
    ST_MUL,
    ST_CHK,
    ST_DIV
  } state_t;

  typedef struct packed {
    func_t             func;
    logic [OFF_W-1:0]  offset;
  } cmd_t;

  typedef struct packed {
    status_t           status;
    logic [OFF_W-1:0]  block_offset;
  } result_t;

endpackage

### src/fbpa_div.sv
// Iterative offset divider, two quotient bits per cycle.
module fbpa_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [fbpa_pkg::OFF_W-1:0] dividend,
  input  logic [fbpa_pkg::USZ_W-1:0] divisor,
  output logic                       done,
  output logic [fbpa_pkg::QW-1:0]    quot,
  output logic                       exact
);
  import fbpa_pkg::*;

  logic             active;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dsh;
  logic [Q2_W-1:0]  q;

  logic [DIV_W-1:0] rem_next;
  logic [DIV_W-1:0] dsh_next;
  logic [Q2_W-1:0]  q_next;

  always_comb begin
    rem_next = rem;
    dsh_next = dsh;
    q_next   = q;
    for (int i = 0; i < 2; i++) begin
      if (rem_next >= dsh_next) begin
        rem_next = rem_next - dsh_next;
        q_next   = {q_next[Q2_W-2:0], 1'b1};
      end else begin
        q_next   = {q_next[Q2_W-2:0], 1'b0};
      end
      dsh_next = dsh_next >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= '0;
      end else if (active) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= DIV_W'(dividend);
      dsh <= DIV_W'(divisor) << (Q2_W - 1);
      q   <= '0;
    end else if (active) begin
      rem <= rem_next;
      dsh <= dsh_next;
      q   <= q_next;
    end
  end

  assign quot  = q[QW-1:0];
  assign exact = (rem == '0);

`ifndef NO_ASSERTIONS
  a_start_runs: assert property (@(posedge clk) disable iff (rst) start |=> active)
    else $error("divider did not start");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !active)
    else $error("divider done while active");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    active |-> (cnt < CNT_W'(DIV_STEPS)))
    else $error("divider step count overrun");
`endif

endmodule

### src/fixed_block_pool_allocator_top.sv
// Fixed block pool allocator: free list in a link RAM plus bump pointer.
// Usage:
//   Commands are taken on start while busy is low. cmd.func selects
//   allocate or free; cmd.offset is the byte offset to free.
//   Each command gives exactly one result beat: done is high for one cycle
//   with result.status and result.block_offset. The receiver cannot stall.
//   Steps from the accepting edge to the result beat:
//     allocate, free list pop: link RAM read, then one multiply
//     allocate, bump pointer:  one multiply
//     allocate, exhausted:     result registered directly
//     free, out of range:      bound multiply and compare
//     free, in range:          bound multiply and compare, then divider (two quotient bits/cycle)
//   One command at a time; busy drops in the cycle the result beat shows,
//   so a new command may be accepted in that same cycle.
//   Config: cfg_we writes register cfg_index (0 block bytes, 1 pool_units)
//   at once; write only while busy is low and no result is pending.
//   Reset: free list empty, bump pointer zero, block bytes 8, pool_units 1024.
//   Link RAM contents are not cleared; only links pushed earlier are read.
module fixed_block_pool_allocator_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  fbpa_pkg::cmd_t                 cmd,
  output logic                           done,
  output fbpa_pkg::result_t              result,
  input  logic                           cfg_we,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fbpa_pkg::CFG_W-1:0]     cfg_data
);
  import fbpa_pkg::*;

  logic [USZ_W-1:0]   blk_bytes;
  logic [UNITS_W-1:0] pool_units;
  logic [USZ_W-1:0]   usz_eff;
  logic [IDX_W-1:0]   units_eff;

  state_t             state, state_next;
  logic [IDX_W-1:0]   free_head, free_head_next;
  logic [IDX_W-1:0]   bump_ptr, bump_ptr_next;
  logic [IDX_W-1:0]   blk, blk_next;
  logic [OFF_W-1:0]   op_offset;
  logic [PROD_W-1:0]  prod;
  logic [IDX_W-1:0]   mul_a;
  result_t            res, res_next;
  logic               done_next;

  logic [IDX_W-1:0]   links [POOL_DEPTH];
  logic [IDX_W-1:0]   link_rd;
  logic               mem_re, mem_we;

  logic               div_start, div_done, div_exact;
  logic [QW-1:0]      quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      blk_bytes  <= USZ_W'(MIN_UNIT);
      pool_units <= UNITS_W'(POOL_DEPTH);
    end else if (cfg_we) begin
      if (cfg_index == CFG_UNIT_SIZE) begin
        blk_bytes <= cfg_data[USZ_W-1:0];
      end
      if (cfg_index == CFG_POOL_UNITS) begin
        pool_units <= cfg_data[UNITS_W-1:0];
      end
    end
  end

  assign usz_eff   = (blk_bytes < USZ_W'(MIN_UNIT)) ? USZ_W'(MIN_UNIT) : blk_bytes;
  assign units_eff = (32'(pool_units) > POOL_DEPTH) ? IDX_W'(POOL_DEPTH)
                                                    : IDX_W'(pool_units);

  assign busy = (state != ST_IDLE);

  always_comb begin
    state_next     = state;
    free_head_next = free_head;
    bump_ptr_next  = bump_ptr;
    blk_next       = blk;
    res_next       = res;
    done_next      = 1'b0;
    mem_re         = 1'b0;
    mem_we         = 1'b0;
    div_start      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (cmd.func == FUNC_ALLOC) begin
            if (free_head != NULL_IDX) begin
              blk_next   = free_head;
              mem_re     = 1'b1;
              state_next = ST_POP;
            end else if (bump_ptr < units_eff) begin
              blk_next      = bump_ptr;
              bump_ptr_next = bump_ptr + IDX_W'(1);
              state_next    = ST_MUL;
            end else begin
              res_next.status       = STAT_EXHAUSTED;
              res_next.block_offset = '0;
              done_next             = 1'b1;
            end
          end else begin
            state_next = ST_CHK;
          end
        end
      end
      ST_POP: begin
        free_head_next = link_rd;
        state_next     = ST_MUL;
      end
      ST_MUL: begin
        res_next.status       = STAT_OK;
        res_next.block_offset = prod[OFF_W-1:0];
        done_next             = 1'b1;
        state_next            = ST_IDLE;
      end
      ST_CHK: begin
        if (PROD_W'(op_offset) < prod) begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end else begin
          res_next.status       = STAT_BAD_OFFSET;
          res_next.block_offset = '0;
          done_next             = 1'b1;
          state_next            = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          res_next.block_offset = '0;
          done_next             = 1'b1;
          state_next            = ST_IDLE;
          if (div_exact) begin
            mem_we          = 1'b1;
            free_head_next  = IDX_W'(quot);
            res_next.status = STAT_OK;
          end else begin
            res_next.status = STAT_BAD_OFFSET;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // bound on free accept, block index otherwise
  assign mul_a = (state == ST_IDLE && cmd.func == FUNC_FREE) ? units_eff : blk_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      free_head <= NULL_IDX;
      bump_ptr  <= '0;
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      free_head <= free_head_next;
      bump_ptr  <= bump_ptr_next;
      done      <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    blk  <= blk_next;
    res  <= res_next;
    prod <= PROD_W'(mul_a) * PROD_W'(usz_eff);
    if (state == ST_IDLE && start) begin
      op_offset <= cmd.offset;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      links[quot] <= free_head;
    end
    if (mem_re) begin
      link_rd <= links[free_head[QW-1:0]];
    end
  end

  fbpa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (op_offset),
    .divisor  (usz_eff),
    .done     (div_done),
    .quot     (quot),
    .exact    (div_exact)
  );

  assign result = res;

`ifndef NO_ASSERTIONS
  a_head_range: assert property (@(posedge clk) disable iff (rst) free_head <= NULL_IDX)
    else $error("free list head out of range");
  a_bump_range: assert property (@(posedge clk) disable iff (rst)
    bump_ptr <= IDX_W'(POOL_DEPTH))
    else $error("bump pointer out of range");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != STAT_OK) |-> (result.block_offset == '0))
    else $error("error beat with nonzero offset");
  a_pop_after_read: assert property (@(posedge clk) disable iff (rst)
    (state == ST_POP) |-> ($past(state) == ST_IDLE && $past(mem_re)))
    else $error("pop without link read");
`endif

endmodule

### dv/fixed_block_pool_allocator_top_test.sv
// Self-checking testbench for the fixed block pool allocator: random and directed commands.
module fixed_block_pool_allocator_top_test;
  import fbpa_pkg::*;

  localparam int WD_LIMIT = 3000;
  localparam int PHASES   = 14;
  localparam int BURST    = 42;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  cmd_t cmd = '0;
  logic done;
  result_t result;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  fixed_block_pool_allocator_top u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // allocator shadow
  int unsigned unit_reg = 8;
  int unsigned units_reg = 1024;
  int unsigned free_head = POOL_DEPTH;
  int unsigned bump_next = 0;
  int unsigned link_mem [POOL_DEPTH];

  cmd_t cmd_q[$];
  result_t want_q[$];
  logic [OFF_W-1:0] held_offs[$];
  int pending = 0;
  int gap_pct = 35;
  bit took = 1'b0;
  int mismatches = 0;
  int quiet_cycles = 0;
  int n_cmds = 0;
  int n_alloc_ok = 0;
  int n_exhausted = 0;
  int n_free_ok = 0;
  int n_bad_free = 0;
  result_t got_w;

  function automatic int unsigned eff_unit();
    return (unit_reg < MIN_UNIT) ? MIN_UNIT : unit_reg;
  endfunction

  function automatic int unsigned eff_units();
    return (units_reg > POOL_DEPTH) ? POOL_DEPTH : units_reg;
  endfunction

  function automatic result_t pool_step(cmd_t c);
    result_t r;
    int unsigned usz;
    int unsigned units;
    int unsigned blk;
    usz = eff_unit();
    units = eff_units();
    r.status = STAT_OK;
    r.block_offset = '0;
    blk = 0;
    if (c.func == FUNC_ALLOC) begin
      if (free_head < POOL_DEPTH) begin
        blk = free_head;
        free_head = link_mem[blk[QW-1:0]];
      end else if (bump_next < units) begin
        blk = bump_next;
        bump_next++;
      end else begin
        r.status = STAT_EXHAUSTED;
      end
      if (r.status == STAT_OK) begin
        r.block_offset = OFF_W'(blk * usz);
        held_offs.push_back(r.block_offset);
        if (held_offs.size() > 64) void'(held_offs.pop_front());
      end
    end else begin
      blk = c.offset / usz;
      if ((c.offset % usz) != 0 || blk >= units) begin
        r.status = STAT_BAD_OFFSET;
      end else begin
        link_mem[blk[QW-1:0]] = free_head;
        free_head = blk;
      end
    end
    return r;
  endfunction

  task automatic note_mismatch(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // driver
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || took) begin
      if (cmd_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
        start <= 1'b1;
        cmd <= cmd_q.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor and scoreboard
  always @(posedge clk) begin
    took = 1'b0;
    if (!rst) begin
      if (done) begin
        if (want_q.size() == 0) begin
          note_mismatch("result beat with nothing outstanding");
        end else begin
          got_w = want_q.pop_front();
          pending--;
          if (result.status !== got_w.status)
            note_mismatch($sformatf("status %0d, want %0d", result.status, got_w.status));
          if (result.block_offset !== got_w.block_offset)
            note_mismatch($sformatf("block_offset 0x%0h, want 0x%0h",
                                    result.block_offset, got_w.block_offset));
        end
      end
      if (start && !busy) begin
        took = 1'b1;
        got_w = pool_step(cmd);
        want_q.push_back(got_w);
        n_cmds++;
        case (got_w.status)
          STAT_OK: begin
            if (cmd.func == FUNC_ALLOC) n_alloc_ok++;
            else n_free_ok++;
          end
          STAT_EXHAUSTED: n_exhausted++;
          default: n_bad_free++;
        endcase
      end
      if (took || done) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles == WD_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", WD_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic push_cmd(func_t f, logic [OFF_W-1:0] o);
    cmd_t c;
    c.func = f;
    c.offset = o;
    cmd_q.push_back(c);
    pending++;
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (pending != 0 || busy);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == CFG_UNIT_SIZE) unit_reg = 32'(val);
    else units_reg = 32'(val[UNITS_W-1:0]);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic pick_config(int p);
    logic [CFG_W-1:0] u;
    logic [CFG_W-1:0] n;
    u = ($urandom_range(3) == 0) ? CFG_W'($urandom) : CFG_W'($urandom_range(8, 64));
    n = {5'($urandom), 11'($urandom_range(1, 24))};
    case (p)
      0: begin u = 8; n = 16; end
      3: begin u = 16'hFFFF; n = 1024; end
      6: begin u = 3; n = 1; end
      9: n = 16'hFFFF;
      12: n = 0;
      default: if ($urandom_range(4) == 0) n = CFG_W'($urandom);
    endcase
    set_reg(CFG_UNIT_SIZE, u);
    set_reg(CFG_POOL_UNITS, n);
  endtask

  task automatic random_burst(int n);
    int unsigned usz;
    int unsigned units;
    int unsigned r;
    int unsigned idx;
    logic [OFF_W-1:0] o;
    usz = eff_unit();
    units = eff_units();
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      o = OFF_W'(usz * $urandom_range(0, units + 1));
      if (r < 45) begin
        push_cmd(FUNC_ALLOC, OFF_W'($urandom));
      end else if (r < 75) begin
        if (held_offs.size() != 0) begin
          idx = $urandom_range(0, held_offs.size() - 1);
          o = held_offs[idx];
          if ($urandom_range(3) != 0) held_offs.delete(idx);
        end
        push_cmd(FUNC_FREE, o);
      end else if (r < 88) begin
        push_cmd(FUNC_FREE, o);
      end else if (r < 94) begin
        push_cmd(FUNC_FREE, OFF_W'($urandom));
      end else begin
        push_cmd(FUNC_FREE, o + OFF_W'($urandom_range(1, usz - 1)));
      end
    end
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // reset config: bump, pop order, misaligned, out of range, double free
    push_cmd(FUNC_ALLOC, '0);
    push_cmd(FUNC_ALLOC, '1);
    push_cmd(FUNC_FREE, 8);
    push_cmd(FUNC_ALLOC, '0);
    push_cmd(FUNC_FREE, 0);
    push_cmd(FUNC_FREE, 8);
    push_cmd(FUNC_ALLOC, '0);
    push_cmd(FUNC_ALLOC, '0);
    push_cmd(FUNC_ALLOC, '0);
    push_cmd(FUNC_FREE, 3);
    push_cmd(FUNC_FREE, 8 * 1024);
    push_cmd(FUNC_FREE, 8 * 1023);
    push_cmd(FUNC_FREE, '1);
    push_cmd(FUNC_FREE, 0);
    push_cmd(FUNC_FREE, 0);
    push_cmd(FUNC_ALLOC, '0);
    push_cmd(FUNC_ALLOC, '0);
    push_cmd(FUNC_ALLOC, '0);
    wait_idle();

    // unit below minimum, empty pool
    set_reg(CFG_UNIT_SIZE, 5);
    set_reg(CFG_POOL_UNITS, 0);
    push_cmd(FUNC_ALLOC, '0);
    push_cmd(FUNC_FREE, 0);
    push_cmd(FUNC_FREE, 8);
    wait_idle();

    // largest unit, pool count saturated
    set_reg(CFG_UNIT_SIZE, 16'hFFFF);
    set_reg(CFG_POOL_UNITS, 2047);
    push_cmd(FUNC_ALLOC, '0);
    push_cmd(FUNC_FREE, OFF_W'(65535 * 1023));
    push_cmd(FUNC_FREE, OFF_W'(65535 * 1024));
    push_cmd(FUNC_ALLOC, '0);
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      gap_pct = (p < 5) ? 35 : (p < 10) ? 73 : 0;
      pick_config(p);
      random_burst(BURST);
      wait_idle();
    end

    repeat (20) @(posedge clk);
    while (want_q.size() != 0) begin
      void'(want_q.pop_front());
      note_mismatch("expected result never arrived");
    end
    $display("covered %0d commands: %0d allocs ok, %0d exhausted, %0d frees ok, %0d bad frees",
             n_cmds, n_alloc_ok, n_exhausted, n_free_ok, n_bad_free);
    $display("%0d config phases incl. min/max unit and empty/saturated pool; %0d mismatches",
             PHASES + 2, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
